/* hw/rtl/record_sort_and_score_search_macros.svh */
// Assertion helpers shared by the RTL
`ifndef RECORD_SORT_AND_SCORE_SEARCH_MACROS_SVH
`define RECORD_SORT_AND_SCORE_SEARCH_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define RSS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define RSS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/rss_pkg.sv */
package rss_pkg;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned NAME_W  = 64;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [NAME_W-1:0]  t_name;

    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_SORT = 2'd1;
    localparam t_cmd CMD_LIST = 2'd2;
    localparam t_cmd CMD_SEEK = 2'd3;
endpackage

/* hw/rtl/record_sort_and_score_search.sv */
// Record store with two-key insertion sort and score search.
// Input: a command is taken at a rising edge with start high and busy low.
//   LOAD appends {score, name} (start_new empties the list first); a load
//   into a full list is dropped. LOAD leaves busy low and gives no result.
//   SORT orders by score descending, then name ascending, in place. It gives
//   no result and keeps busy high while it runs; while shifting it makes one
//   compare per cycle, bounded by the single read port of the record memory.
//   LIST emits every record in stored order; SEEK emits each record whose
//   score matches, or one result with found low. Both walk the memory at one
//   record a cycle; LIST on an empty list stays idle, SEEK on an empty list
//   goes straight to its single not-found result. Each LIST result is read
//   in S_SCAN, then registered in r_rd and r_orec; SEEK holds each match back
//   until the next match or the end of the walk is known.
// Output: each result sits on the o_ ports for one cycle with o_strobe high;
//   o_last marks the final result of a command. The receiver cannot stall.
// Reset clears the record count and control; memory contents stay as they
// are and an entry is never used before it is written.
module record_sort_and_score_search #(
    parameter int unsigned MAX_RECORDS = 64,
    parameter int unsigned NAME_BYTES  = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rss_pkg::t_cmd   i_command,
    input  rss_pkg::t_score i_score,
    input  rss_pkg::t_name  i_name,
    input  logic            i_start_new,
    output logic            o_strobe,
    output rss_pkg::t_name  o_name_res,
    output rss_pkg::t_score o_score_res,
    output logic            o_found,
    output logic            o_last
);
    import rss_pkg::*;

    `include "record_sort_and_score_search_macros.svh"

    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
    localparam int unsigned NW = NAME_BYTES * 8;
    localparam int unsigned RW = SCORE_W + NW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_SK    = 3'd4;
    localparam logic [2:0] S_SKEY  = 3'd5;
    localparam logic [2:0] S_SCMP  = 3'd6;
    localparam logic [2:0] S_SPUT  = 3'd7;

    logic [RW-1:0] r_mem [MAX_RECORDS];
    logic [RW-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [RW-1:0] wr_data;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [RW-1:0] r_key, n_key;
    logic          r_iss, n_iss;
    logic          r_iss_last, n_iss_last;
    logic          r_seek, n_seek;
    t_score        r_sc, n_sc;
    logic          r_hv, n_hv;
    logic [RW-1:0] r_hold, n_hold;
    logic          r_ov, n_ov;
    logic [RW-1:0] r_orec, n_orec;
    logic          r_of, n_of;
    logic          r_ol, n_ol;

    logic          key_ahead;
    logic          match;
    logic          sort_end;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // key goes ahead of the record just read
    assign key_ahead = (r_key[RW-1:NW] != r_rd[RW-1:NW]) ? (r_key[RW-1:NW] > r_rd[RW-1:NW])
                                                           : (r_key[NW-1:0] < r_rd[NW-1:0]);
    assign match    = (r_rd[RW-1:NW] == r_sc);
    assign sort_end = ((CW'(r_i) + CW'(1)) == r_cnt);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_key      = r_key;
        n_iss      = 1'b0;
        n_iss_last = 1'b0;
        n_seek     = r_seek;
        n_sc       = r_sc;
        n_hv       = r_hv;
        n_hold     = r_hold;
        n_ov       = 1'b0;
        n_orec     = r_orec;
        n_of       = 1'b1;
        n_ol       = 1'b0;
        rd_addr    = r_i;
        we         = 1'b0;
        wr_addr    = r_j;
        wr_data    = r_key;

        // result of the read issued last cycle
        if (r_iss) begin
            if (!r_seek) begin
                n_ov   = 1'b1;
                n_orec = r_rd;
                n_ol   = r_iss_last;
            end else if (match) begin
                if (r_hv) begin
                    n_ov   = 1'b1;
                    n_orec = r_hold;
                end
                n_hv   = 1'b1;
                n_hold = r_rd;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        CMD_LOAD: begin
                            wr_addr = i_start_new ? '0 : r_cnt[AW-1:0];
                            wr_data = {i_score, i_name[NW-1:0]};
                            if (i_start_new) begin
                                we    = 1'b1;
                                n_cnt = CW'(1);
                            end else if (r_cnt < CW'(MAX_RECORDS)) begin
                                we    = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        CMD_SORT: begin
                            if (r_cnt > CW'(1)) begin
                                n_i     = AW'(1);
                                n_state = S_SK;
                            end
                        end
                        CMD_LIST, CMD_SEEK: begin
                            n_seek = (i_command == CMD_SEEK);
                            n_sc   = i_score;
                            n_hv   = 1'b0;
                            n_i    = '0;
                            if (r_cnt != '0) begin
                                n_state = S_SCAN;
                            end else if (i_command == CMD_SEEK) begin
                                n_state = S_FIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                rd_addr = r_i;
                n_iss   = 1'b1;
                if ((CW'(r_i) + CW'(1)) == r_cnt) begin
                    n_iss_last = 1'b1;
                    n_state    = S_DRAIN;
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_seek ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                n_ov    = 1'b1;
                n_ol    = 1'b1;
                n_of    = r_hv;
                n_orec  = r_hv ? r_hold : '0;
                n_state = S_IDLE;
            end
            S_SK: begin
                rd_addr = r_i;
                n_state = S_SKEY;
            end
            S_SKEY: begin
                n_key   = r_rd;
                n_j     = r_i;
                rd_addr = r_i - AW'(1);
                n_state = S_SCMP;
            end
            S_SCMP: begin
                we      = 1'b1;
                wr_addr = r_j;
                if (key_ahead) begin
                    wr_data = r_rd;
                    n_j     = r_j - AW'(1);
                    rd_addr = r_j - AW'(2);
                    if (r_j == AW'(1)) begin
                        n_state = S_SPUT;
                    end
                end else begin
                    wr_data = r_key;
                    n_i     = r_i + AW'(1);
                    n_state = sort_end ? S_IDLE : S_SK;
                end
            end
            S_SPUT: begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = r_key;
                n_i     = r_i + AW'(1);
                n_state = sort_end ? S_IDLE : S_SK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_iss      <= 1'b0;
            r_iss_last <= 1'b0;
            r_hv       <= 1'b0;
            r_ov       <= 1'b0;
            r_seek     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_iss      <= n_iss;
            r_iss_last <= n_iss_last;
            r_hv       <= n_hv;
            r_ov       <= n_ov;
            r_seek     <= n_seek;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_key  <= n_key;
        r_sc   <= n_sc;
        r_hold <= n_hold;
        r_orec <= n_orec;
        r_of   <= n_of;
        r_ol   <= n_ol;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_ov;
    assign o_name_res  = NAME_W'(r_orec[NW-1:0]);
    assign o_score_res = r_orec[RW-1:NW];
    assign o_found     = r_of;
    assign o_last      = r_ol;

    `RSS_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(MAX_RECORDS))
    `RSS_ASSERT_IMPLY(a_miss_last, i_clk, i_rst_n, o_strobe && !o_found, o_last)
    `RSS_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, o_strobe && !o_found,
        (o_name_res == '0) && (o_score_res == '0))
    `RSS_ASSERT_IMPLY(a_iss_busy, i_clk, i_rst_n, r_iss && !r_iss_last, busy)
endmodule
